// File: design/dirty_index_tracker_defines.svh
// ============================================================================
// dirty_index_tracker_defines.svh
// Assertion macros shared by the dirty index tracker RTL.
// ============================================================================
`ifndef DIRTY_INDEX_TRACKER_DEFINES_SVH
`define DIRTY_INDEX_TRACKER_DEFINES_SVH

// Check a property on every rising clock edge, also during reset.
`define DIT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

// Check a property on rising clock edges outside reset.
`define DIT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

// File: design/dit_pkg.sv
// ============================================================================
// dit_pkg
// Shared types and constants of the dirty index tracker.
// ============================================================================
`timescale 1ns / 1ps

package dit_pkg;

	// Default table capacity
	localparam int DEF_CAPACITY = 256;

	// Field widths
	localparam int FUNC_W  = 2;
	localparam int INDEX_W = 8;
	localparam int SLOT_W  = 8;
	localparam int COUNT_W = 9;
	localparam int ENTRY_W = 8;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Input request
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [INDEX_W-1:0] index;
		logic [SLOT_W-1:0]  slot;
	} req_t;

	// Result
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [ENTRY_W-1:0] entry;
		logic               newly_added;
		logic               rejected;
	} rsp_t;

endpackage

// File: design/dirty_index_tracker.sv
// ============================================================================
// dirty_index_tracker
// Change list over a table of indices: mark, clear and read of list entries.
// ============================================================================
`timescale 1ns / 1ps
`include "dirty_index_tracker_defines.svh"

// One request is handled at a time and each gives one result. Mark, read and
// the unused code pass through the execute state, which uses the registered
// read data of the flag memory (mark) and the list memory (read). A clear reads
// the list one position a cycle and wipes the flag of each listed index in the
// cycle after. After reset the flag memory is swept to zero, one entry a cycle,
// over its min(CAPACITY, 256) entries; no request is accepted until that pass is
// done. The result waits in an output register, so a slow consumer stalls the
// block only when the next result is ready.
module dirty_index_tracker #(
	parameter int CAPACITY = dit_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dit_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dit_pkg::rsp_t out_data
);

	// Indices are 8 bits wide, so no more than 256 entries are ever used
	localparam int DEPTH = (CAPACITY < 256) ? CAPACITY : 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_CLR  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                sweep_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             walk_q;
	logic                         wipe_s1;
	dit_pkg::req_t                req_q;
	logic                         out_valid_q;
	dit_pkg::rsp_t                out_q;

	// Memories and their registered read data
	logic                         flag_mem [DEPTH];
	logic [dit_pkg::ENTRY_W-1:0]  order_mem [DEPTH];
	logic                         flag_rd_q;
	logic [dit_pkg::ENTRY_W-1:0]  order_rd_q;

	logic                         flag_we;
	logic [AW-1:0]                flag_wa;
	logic                         flag_wd;
	logic                         flag_re;
	logic [AW-1:0]                flag_ra;
	logic                         order_we;
	logic                         order_re;
	logic [AW-1:0]                order_ra;

	logic                         accept;
	logic                         out_free;
	logic                         mark_in_range;
	logic                         mark_new;
	logic                         read_hit;
	logic                         walk_more;
	logic                         clr_done;
	logic                         exec_done;
	logic [CNT_W-1:0]             count_nxt;
	dit_pkg::rsp_t                rsp_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Decode the held request
	assign mark_in_range = (32'(req_q.index) < CAPACITY);
	assign mark_new      = (req_q.func == dit_pkg::FUNC_MARK) && mark_in_range && !flag_rd_q
		&& (32'(count_q) < DEPTH);
	assign read_hit      = ({1'b0, req_q.slot} < 9'(count_q));
	assign count_nxt     = mark_new ? count_q + CNT_W'(1) : count_q;
	assign exec_done     = (state_q == ST_EXEC) && out_free;
	assign walk_more     = (walk_q < count_q);
	assign clr_done      = (state_q == ST_CLR) && !walk_more && !wipe_s1 && out_free;

	// Build the result of a mark, read or unused code
	always_comb begin
		rsp_d             = '0;
		rsp_d.count       = 9'(count_nxt);
		case (req_q.func)
			dit_pkg::FUNC_MARK: begin
				rsp_d.newly_added = mark_new;
				rsp_d.rejected    = !mark_in_range;
			end
			dit_pkg::FUNC_READ: begin
				rsp_d.entry    = read_hit ? order_rd_q : '0;
				rsp_d.rejected = !read_hit;
			end
			default: begin
			end
		endcase
	end

	// Flag memory port control: sweep, set on mark, wipe on clear
	always_comb begin
		flag_we = 1'b0;
		flag_wa = '0;
		flag_wd = 1'b0;
		case (state_q)
			ST_INIT: begin
				flag_we = 1'b1;
				flag_wa = sweep_q;
			end
			ST_EXEC: begin
				flag_we = exec_done && mark_new;
				flag_wa = req_q.index[AW-1:0];
				flag_wd = 1'b1;
			end
			ST_CLR: begin
				flag_we = wipe_s1;
				flag_wa = order_rd_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign flag_re  = accept && (in_data.func == dit_pkg::FUNC_MARK);
	assign flag_ra  = in_data.index[AW-1:0];

	// List memory: append on mark, read on request or during the clear walk
	assign order_we = exec_done && mark_new;
	assign order_re = (accept && (in_data.func == dit_pkg::FUNC_READ))
		|| ((state_q == ST_CLR) && walk_more);
	assign order_ra = (state_q == ST_CLR) ? walk_q[AW-1:0] : in_data.slot[AW-1:0];

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (flag_re) begin
			flag_rd_q <= flag_mem[flag_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[count_q[AW-1:0]] <= req_q.index;
		end
		if (order_re) begin
			order_rd_q <= order_mem[order_ra];
		end
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
	end

	// Sequence: sweep, wait, execute, walk the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			count_q <= '0;
			walk_q  <= '0;
			wipe_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						walk_q  <= '0;
						wipe_s1 <= 1'b0;
						state_q <= (in_data.func == dit_pkg::FUNC_CLEAR) ? ST_CLR : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_done) begin
						count_q <= count_nxt;
						state_q <= ST_IDLE;
					end
				end
				ST_CLR: begin
					wipe_s1 <= walk_more;
					if (walk_more) begin
						walk_q <= walk_q + CNT_W'(1);
					end
					if (clr_done) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_done || clr_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			out_q <= rsp_d;
		end else if (clr_done) begin
			out_q <= '0;
		end
	end

	// Checks
	`DIT_ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= DEPTH, "count exceeds depth")
	`DIT_ASSERT(a_accept_next, accept |=> (state_q == ST_EXEC || state_q == ST_CLR), "bad state after accept")
	`DIT_ASSERT(a_mark_incr, (exec_done && mark_new) |=> count_q == $past(count_q) + CNT_W'(1), "mark did not advance count")
	`DIT_ASSERT(a_result_kind, out_valid_q |-> !(out_q.newly_added && out_q.rejected), "added and rejected together")

endmodule
